// ----- design/multi_channel_pulse_oscillator_unit_macros.svh -----
// Assertion helpers for the pulse oscillator RTL.
`ifndef MULTI_CHANNEL_PULSE_OSCILLATOR_UNIT_MACROS_SVH
`define MULTI_CHANNEL_PULSE_OSCILLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while in reset.
`define MCPO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while in reset.
`define MCPO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mcpo_pkg.sv -----
`default_nettype none

package mcpo_pkg;

  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int TIME_WIDTH_DEF    = 16;

  // Fixed field widths of the transactions.
  localparam int MODE_W    = 2;
  localparam int CHANNEL_W = 3;
  localparam int CMD_TIME_W = 16;
  localparam int OUT_W     = 4;

  // Power-on period, in milliseconds.
  localparam logic [31:0] RESET_HIGH_TIME = 32'd1000;
  localparam logic [31:0] RESET_LOW_TIME  = 32'd2000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

endpackage

`default_nettype wire

// ----- design/mcpo_in_if.sv -----
`default_nettype none

interface mcpo_in_if;
  logic                               valid;
  logic                               ready;
  logic [mcpo_pkg::MODE_W-1:0]        mode;
  logic [mcpo_pkg::CHANNEL_W-1:0]     channel;
  logic [mcpo_pkg::CMD_TIME_W-1:0]    on_time;
  logic [mcpo_pkg::CMD_TIME_W-1:0]    off_time;

  modport source (output valid, output mode, output channel, output on_time,
                  output off_time, input ready);
  modport sink   (input valid, input mode, input channel, input on_time,
                  input off_time, output ready);
endinterface

`default_nettype wire

// ----- design/mcpo_out_if.sv -----
`default_nettype none

interface mcpo_out_if;
  logic                        valid;
  logic                        ready;
  logic [mcpo_pkg::OUT_W-1:0]  pin_levels;
  logic [mcpo_pkg::OUT_W-1:0]  running_mask;

  modport source (output valid, output pin_levels, output running_mask, input ready);
  modport sink   (input valid, input pin_levels, input running_mask, output ready);
endinterface

`default_nettype wire

// ----- design/multi_channel_pulse_oscillator_unit.sv -----
// Multi-channel pulse oscillator. Each of CHANNEL_COUNT channels is idle, on
// (pin high) or off (pin low) with a millisecond countdown of TIME_WIDTH bits.
// A cmd transaction is a tick (mode 0: every running countdown advances; at
// zero or one the channel toggles and reloads the other phase's time), a start
// (mode 1: store on/off times, on time 0 taken as 1; an idle channel also goes
// high and loads its on time) or a stop (mode 2: channel goes low and idle,
// countdown kept). Start or stop on a channel at or above CHANNEL_COUNT, and
// mode 3, change nothing. Times wider than TIME_WIDTH saturate. Every cmd
// transaction yields exactly one result transaction carrying the updated pin
// levels and running mask (bit i for channel i, bits past the channel count
// read 0). Throughput is one transaction per clock without result backpressure;
// each passes through the input register and the result register, with all
// channels updated in parallel between them. Result backpressure stalls the
// input register, and cmd.ready falls only once both registers are full. No
// clearing pass follows reset: the block is ready as soon as rst falls.
`default_nettype none

module multi_channel_pulse_oscillator_unit #(
  parameter int CHANNEL_COUNT = mcpo_pkg::CHANNEL_COUNT_DEF,
  parameter int TIME_WIDTH    = mcpo_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mcpo_in_if.sink           cmd,
  mcpo_out_if.source        result
);

  `include "multi_channel_pulse_oscillator_unit_macros.svh"

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  // Saturate a millisecond count to the countdown width.
  function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [31:0] v);
    logic [32:0] max_ext;
    max_ext = 33'(TIME_MAX);
    if ({1'b0, v} > max_ext) begin
      return TIME_MAX;
    end
    return v[TIME_WIDTH-1:0];
  endfunction

  // Input register.
  logic                              s1_valid;
  logic [mcpo_pkg::MODE_W-1:0]       s1_mode;
  logic [mcpo_pkg::CHANNEL_W-1:0]    s1_channel;
  logic [mcpo_pkg::CMD_TIME_W-1:0]   s1_on_time;
  logic [mcpo_pkg::CMD_TIME_W-1:0]   s1_off_time;
  logic                              s1_fire;

  // Channel state.
  mcpo_pkg::phase_t                  phase          [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0]             remaining      [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0]             high_time      [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0]             low_time       [CHANNEL_COUNT];
  mcpo_pkg::phase_t                  phase_next     [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0]             remaining_next [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0]             high_time_next [CHANNEL_COUNT];
  logic [TIME_WIDTH-1:0]             low_time_next  [CHANNEL_COUNT];

  logic [TIME_WIDTH-1:0]             start_high;
  logic [TIME_WIDTH-1:0]             start_low;
  logic [mcpo_pkg::OUT_W-1:0]        levels_next;
  logic [mcpo_pkg::OUT_W-1:0]        running_next;

  // Advance the input register whenever the result register is free or drains.
  assign s1_fire   = s1_valid && (!result.valid || result.ready);
  assign cmd.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_mode     <= cmd.mode;
      s1_channel  <= cmd.channel;
      s1_on_time  <= cmd.on_time;
      s1_off_time <= cmd.off_time;
    end
  end

  // A start raises a zero on time to one.
  assign start_high = clamp_time((s1_on_time == '0) ? 32'd1 : 32'(s1_on_time));
  assign start_low  = clamp_time(32'(s1_off_time));

  // Per-channel update; channels are independent of each other.
  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      phase_next[c]     = phase[c];
      remaining_next[c] = remaining[c];
      high_time_next[c] = high_time[c];
      low_time_next[c]  = low_time[c];
      case (s1_mode)
        mcpo_pkg::MODE_TICK: begin
          if (phase[c] == mcpo_pkg::PH_ON || phase[c] == mcpo_pkg::PH_OFF) begin
            if (remaining[c] <= TIME_WIDTH'(1)) begin
              // Expired: toggle and reload the phase being entered.
              if (phase[c] == mcpo_pkg::PH_ON) begin
                phase_next[c]     = mcpo_pkg::PH_OFF;
                remaining_next[c] = low_time[c];
              end else begin
                phase_next[c]     = mcpo_pkg::PH_ON;
                remaining_next[c] = high_time[c];
              end
            end else begin
              remaining_next[c] = remaining[c] - TIME_WIDTH'(1);
            end
          end
        end
        mcpo_pkg::MODE_START: begin
          // A channel index matching c is in range by construction.
          if (s1_channel == mcpo_pkg::CHANNEL_W'(c)) begin
            high_time_next[c] = start_high;
            low_time_next[c]  = start_low;
            if (phase[c] == mcpo_pkg::PH_IDLE) begin
              phase_next[c]     = mcpo_pkg::PH_ON;
              remaining_next[c] = start_high;
            end
          end
        end
        mcpo_pkg::MODE_STOP: begin
          if (s1_channel == mcpo_pkg::CHANNEL_W'(c)) begin
            phase_next[c] = mcpo_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        phase[c]     <= mcpo_pkg::PH_IDLE;
        remaining[c] <= '0;
        high_time[c] <= clamp_time(mcpo_pkg::RESET_HIGH_TIME);
        low_time[c]  <= clamp_time(mcpo_pkg::RESET_LOW_TIME);
      end
    end else if (s1_fire) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        phase[c]     <= phase_next[c];
        remaining[c] <= remaining_next[c];
        high_time[c] <= high_time_next[c];
        low_time[c]  <= low_time_next[c];
      end
    end
  end

  // Report the low four channels; missing channels read as idle.
  for (genvar b = 0; b < mcpo_pkg::OUT_W; b++) begin : g_report
    if (b < CHANNEL_COUNT) begin : g_live
      assign levels_next[b]  = (phase_next[b] == mcpo_pkg::PH_ON);
      assign running_next[b] = (phase_next[b] != mcpo_pkg::PH_IDLE);
    end else begin : g_absent
      assign levels_next[b]  = 1'b0;
      assign running_next[b] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.pin_levels   <= levels_next;
      result.running_mask <= running_next;
    end
  end

  `MCPO_ASSERT_NOW(a_level_implies_running, result.valid,
    (result.pin_levels & ~result.running_mask) == '0,
    "pin high on a channel that is not running")

  `MCPO_ASSERT_NOW(a_result_from_stage, $rose(result.valid), $past(s1_fire),
    "result appeared without a transaction leaving the input register")

  `MCPO_ASSERT_NEXT(a_stop_idles, s1_fire && s1_mode == mcpo_pkg::MODE_STOP && s1_channel == '0,
    result.valid && !result.running_mask[0] && !result.pin_levels[0],
    "stop left channel zero running")

  `MCPO_ASSERT_NEXT(a_start_drives_high,
    s1_fire && s1_mode == mcpo_pkg::MODE_START && s1_channel == '0 && phase[0] == mcpo_pkg::PH_IDLE,
    result.valid && result.pin_levels[0] && result.running_mask[0],
    "start on idle channel zero did not drive it high")

endmodule

`default_nettype wire
